>>> rtl/brf_pkg.sv
// Shared constants and types for the byte ring FIFO.
`timescale 1ns / 1ps

package brf_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int LANES_DEF = 8;
	localparam int CNT_W     = 4;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	// Per-transaction control handed to every bank lane
	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [CNT_W-1:0] count;
	} lane_ctl_t;

endpackage

>>> rtl/brf_req_if.sv
// Request channel: push or pop of up to LANES bytes.
`timescale 1ns / 1ps

interface brf_req_if import brf_pkg::*; #(
	parameter int LANES = LANES_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [CNT_W-1:0]     byte_count;
	logic [8*LANES-1:0]   push_bytes;

	modport source (output valid, output func, output byte_count, output push_bytes,
		input ready);
	modport sink (input valid, input func, input byte_count, input push_bytes,
		output ready);
endinterface

>>> rtl/brf_rsp_if.sv
// Response channel: bytes moved, popped data and fill level.
`timescale 1ns / 1ps

interface brf_rsp_if import brf_pkg::*; #(
	parameter int LANES = LANES_DEF,
	parameter int DEPTH = DEPTH_DEF
) ();
	localparam int PW = $clog2(DEPTH) + 1;

	logic                 valid;
	logic                 ready;
	logic [CNT_W-1:0]     done_count;
	logic [8*LANES-1:0]   pop_bytes;
	logic [PW-1:0]        fill_level;

	modport source (output valid, output done_count, output pop_bytes, output fill_level,
		input ready);
	modport sink (input valid, input done_count, input pop_bytes, input fill_level,
		output ready);
endinterface

>>> rtl/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/brf_lane.sv
// One byte bank: picks its byte of a transaction and holds its slice of the ring.
`timescale 1ns / 1ps

module brf_lane import brf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int BANKS = 8
) (
	input  logic                     clk,
	input  lane_ctl_t                ctl,
	input  logic [$clog2(BANKS)-1:0] bank_id,
	input  logic [$clog2(DEPTH)-1:0] wr_base,
	input  logic [$clog2(DEPTH)-1:0] rd_base,
	input  logic [8*BANKS-1:0]       wr_data,
	output logic [7:0]               rdata
);
	localparam int AW   = $clog2(DEPTH);
	localparam int BW   = $clog2(BANKS);
	localparam int ROWS = DEPTH / BANKS;

	logic [BW-1:0] wr_idx;
	logic [BW-1:0] rd_idx;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          we;

	// Offset of this bank's byte within the transaction
	assign wr_idx  = bank_id - wr_base[BW-1:0];
	assign rd_idx  = bank_id - rd_base[BW-1:0];
	assign wr_addr = wr_base + AW'(wr_idx);
	assign rd_addr = rd_base + AW'(rd_idx);
	assign we      = ctl.wr_en && (CNT_W'(wr_idx) < ctl.count);

	brf_ram #(
		.WIDTH (8),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr[AW-1:BW]),
		.wdata (wr_data[8*wr_idx +: 8]),
		.re    (ctl.rd_en),
		.raddr (rd_addr[AW-1:BW]),
		.rdata (rdata)
	);
endmodule

>>> rtl/byte_ring_fifo_block_transfer.sv
// Byte ring FIFO with all-or-nothing transfers of up to LANES bytes.
// Usage:
//   req carries one transaction: func (push or pop), byte_count and push_bytes.
//   rsp returns one result per transaction: done_count (0 when refused),
//   pop_bytes (zero above done_count and for pushes) and fill_level after it.
//   A push that does not fit in the free space, a pop asking for more bytes
//   than are stored, and any count above LANES are refused and change nothing.
// Timing:
//   A result passes through the registered read of the bank RAMs, then the output
//   register behind the merge stage that rotates bank data into lane order. The
//   store is split into byte banks, as many as LANES rounded up to a power of two
//   (at least two), each read once per cycle, so one transaction per cycle is
//   sustained while rsp.ready stays high.
// Reset:
//   arst_n clears both pointers and all valid flags; stored bytes are left as
//   they are and are never returned before being written.
// Back-pressure:
//   While rsp is stalled the result is held in the output register; one more
//   transaction may be accepted and then held in the merge stage, after which
//   req.ready drops until rsp.ready returns.
`timescale 1ns / 1ps

module byte_ring_fifo_block_transfer import brf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int LANES = LANES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	brf_req_if.sink   req,
	brf_rsp_if.source rsp
);
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW + 1;
	localparam int BANKS = (LANES < 2) ? 2 : (1 << $clog2(LANES));
	localparam int BW    = $clog2(BANKS);

	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW-1:0]      fill;
	logic [PW-1:0]      wr_ptr_nxt;
	logic [PW-1:0]      rd_ptr_nxt;
	logic               accept;
	logic               is_pop;
	logic               cnt_ok;
	logic               push_ok;
	logic               pop_ok;
	logic [CNT_W-1:0]   done;
	lane_ctl_t          ctl;
	logic [8*BANKS-1:0] wr_data;
	logic [7:0]         bank_rdata [BANKS];

	logic               valid_s1;
	logic               pop_s1;
	logic [CNT_W-1:0]   done_s1;
	logic [BW-1:0]      rd_low_s1;
	logic [PW-1:0]      fill_s1;
	logic               go_s1;

	logic               out_valid_q;
	logic [CNT_W-1:0]   done_q;
	logic [8*LANES-1:0] pop_bytes_q;
	logic [PW-1:0]      fill_q;
	logic [8*LANES-1:0] merged;

	assign go_s1     = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || go_s1;
	assign accept    = req.valid && req.ready;

	assign fill   = wr_ptr_q - rd_ptr_q;
	assign is_pop = (func_t'(req.func) == FUNC_POP);
	assign cnt_ok = (req.byte_count <= CNT_W'(LANES));

	assign push_ok = accept && !is_pop && cnt_ok &&
		(({1'b0, fill} + (PW+1)'(req.byte_count)) <= (PW+1)'(DEPTH));
	assign pop_ok  = accept && is_pop && cnt_ok && (PW'(req.byte_count) <= fill);
	assign done    = (push_ok || pop_ok) ? req.byte_count : '0;

	assign wr_ptr_nxt = push_ok ? (wr_ptr_q + PW'(req.byte_count)) : wr_ptr_q;
	assign rd_ptr_nxt = pop_ok  ? (rd_ptr_q + PW'(req.byte_count)) : rd_ptr_q;

	assign ctl.wr_en = push_ok;
	assign ctl.rd_en = pop_ok;
	assign ctl.count = req.byte_count;
	assign wr_data   = (8*BANKS)'(req.push_bytes);

	for (genvar b = 0; b < BANKS; b++) begin : g_lane
		brf_lane #(
			.DEPTH (DEPTH),
			.BANKS (BANKS)
		) u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.bank_id (BW'(b)),
			.wr_base (wr_ptr_q[AW-1:0]),
			.rd_base (rd_ptr_q[AW-1:0]),
			.wr_data (wr_data),
			.rdata   (bank_rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_nxt;
			rd_ptr_q <= rd_ptr_nxt;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= pop_ok;
			done_s1   <= done;
			rd_low_s1 <= rd_ptr_q[BW-1:0];
			fill_s1   <= wr_ptr_nxt - rd_ptr_nxt;
		end
	end

	// Rotate bank data into lane order and blank bytes that were not popped
	for (genvar i = 0; i < LANES; i++) begin : g_merge
		logic [BW-1:0] bank_sel;
		assign bank_sel = rd_low_s1 + BW'(i);
		assign merged[8*i +: 8] = (pop_s1 && (CNT_W'(i) < done_s1)) ?
			bank_rdata[bank_sel] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && valid_s1) begin
			done_q      <= done_s1;
			pop_bytes_q <= merged;
			fill_q      <= fill_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.done_count = done_q;
	assign rsp.pop_bytes  = pop_bytes_q;
	assign rsp.fill_level = fill_q;
endmodule

>>> sim/byte_ring_fifo_block_transfer_tb.sv
// Self-checking testbench for the byte ring FIFO: push and pop traffic checked against a predictor.
`timescale 1ns / 1ps

module byte_ring_fifo_block_transfer_tb;
	import brf_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int LANES       = LANES_DEF;
	localparam int AW          = $clog2(DEPTH);
	localparam int PW          = AW + 1;
	localparam int DW          = 8 * LANES;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int N_RANDOM    = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 10;

	typedef enum {FILLING, DRAINING, MIXING} traffic_t;

	typedef struct {
		func_t            func;
		logic [CNT_W-1:0] count;
		logic [DW-1:0]    data;
		int               gap;
		bit               hold;
	} request_t;

	typedef struct packed {
		logic [CNT_W-1:0] done;
		logic [DW-1:0]    bytes;
		logic [PW-1:0]    fill;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	brf_req_if #(.LANES(LANES)) req_ch ();
	brf_rsp_if #(.LANES(LANES), .DEPTH(DEPTH)) rsp_ch ();

	byte_ring_fifo_block_transfer #(.DEPTH(DEPTH), .LANES(LANES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Predicted store and pointers
	logic [7:0]    fifo_bytes [DEPTH];
	logic [PW-1:0] wr_ptr = '0;
	logic [PW-1:0] rd_ptr = '0;

	request_t request_q[$];
	outcome_t outcome_q[$];
	request_t cur_req;
	int       n_queued = 0, n_accepted = 0, n_errors = 0, cycle_cnt = 0;
	int       gap_cnt = 0, stall_left = 0;
	bit       tx_burst = 1'b0, rx_burst = 1'b0;
	bit       req_busy = 1'b0, req_taken = 1'b0, rsp_taken = 1'b0;

	function automatic outcome_t transfer_outcome(request_t r);
		outcome_t    o;
		logic [PW-1:0] fill;
		int unsigned n;
		o = '0;
		fill = wr_ptr - rd_ptr;
		n = r.count;
		// counts above LANES are refused outright
		if (n <= LANES) begin
			if (r.func == FUNC_PUSH) begin
				if (n <= DEPTH - fill) begin
					for (int i = 0; i < n; i++)
						fifo_bytes[AW'(wr_ptr + PW'(i))] = r.data[8*i +: 8];
					wr_ptr = wr_ptr + PW'(n);
					o.done = CNT_W'(n);
				end
			end else if (n <= fill) begin
				for (int i = 0; i < n; i++)
					o.bytes[8*i +: 8] = fifo_bytes[AW'(rd_ptr + PW'(i))];
				rd_ptr = rd_ptr + PW'(n);
				o.done = CNT_W'(n);
			end
		end
		o.fill = wr_ptr - rd_ptr;
		return o;
	endfunction

	task automatic queue_request(func_t f, int cnt, logic [DW-1:0] d, bit hold = 1'b0);
		request_t r;
		if ($urandom_range(0, 29) == 0)
			tx_burst = !tx_burst;
		r.func  = f;
		r.count = CNT_W'(cnt);
		r.data  = d;
		r.gap   = tx_burst ? 0 : $urandom_range(0, 19);
		r.hold  = hold;
		request_q.push_back(r);
		n_queued++;
	endtask

	initial begin
		int       est_fill, cnt, linger, mixed_left, pick;
		bit       push;
		traffic_t mode;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_PUSH;
		req_ch.byte_count = '0;
		req_ch.push_bytes = '0;
		rsp_ch.ready      = 1'b0;
		arst_n            = 1'b0;

		// Empty store: zero-length, underflow and oversized counts
		queue_request(FUNC_POP, 0, {$urandom, $urandom});
		queue_request(FUNC_POP, 1, {$urandom, $urandom});
		queue_request(FUNC_POP, LANES, {$urandom, $urandom});
		queue_request(FUNC_PUSH, 0, {$urandom, $urandom});
		queue_request(FUNC_PUSH, CNT_MAX, '1);
		queue_request(FUNC_PUSH, LANES + 1, '1);
		queue_request(FUNC_POP, CNT_MAX, {$urandom, $urandom});
		// Full-width pushes of extreme data, then read them back
		queue_request(FUNC_PUSH, LANES, '1);
		queue_request(FUNC_PUSH, LANES, '0);
		queue_request(FUNC_PUSH, 1, {$urandom, $urandom});
		queue_request(FUNC_POP, LANES + 1, '1);
		queue_request(FUNC_POP, CNT_MAX, '1);
		queue_request(FUNC_POP, LANES, {$urandom, $urandom});
		queue_request(FUNC_POP, LANES, {$urandom, $urandom});
		queue_request(FUNC_POP, 2, {$urandom, $urandom});
		queue_request(FUNC_POP, 1, {$urandom, $urandom});
		queue_request(FUNC_PUSH, 5, {LANES{8'hAA}});
		queue_request(FUNC_PUSH, 3, {LANES{8'h55}});
		// Hold the sender until every result is back
		queue_request(FUNC_POP, 0, {$urandom, $urandom}, 1'b1);
		queue_request(FUNC_POP, LANES, '0);

		// Directed part leaves the store empty
		est_fill = 0;
		mode = FILLING;
		linger = 0;
		mixed_left = 0;
		for (int k = 0; k < N_RANDOM; k++) begin
			case (mode)
				FILLING:  push = $urandom_range(0, 99) < 95;
				DRAINING: push = $urandom_range(0, 99) < 5;
				default:  push = $urandom_range(0, 1);
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 5)
				cnt = $urandom_range(LANES + 1, CNT_MAX);
			else if (pick < 10)
				cnt = 0;
			else if (mode != MIXING && pick < 70)
				cnt = LANES;
			else
				cnt = $urandom_range(1, LANES);
			// hit the exact full and empty boundaries now and then
			if (push && DEPTH - est_fill < LANES && $urandom_range(0, 1))
				cnt = DEPTH - est_fill;
			if (!push && est_fill < LANES && $urandom_range(0, 1))
				cnt = est_fill;
			if (cnt <= LANES) begin
				if (push && cnt <= DEPTH - est_fill)
					est_fill += cnt;
				else if (!push && cnt <= est_fill)
					est_fill -= cnt;
			end
			queue_request(push ? FUNC_PUSH : FUNC_POP, cnt, {$urandom, $urandom},
				$urandom_range(0, 99) == 0);

			if (mode == MIXING) begin
				mixed_left--;
				if (mixed_left <= 0)
					mode = FILLING;
			end else if (est_fill == (mode == FILLING ? DEPTH : 0)) begin
				// linger at the boundary so refusals are exercised
				linger++;
				if (linger == 4) begin
					linger = 0;
					if (mode == FILLING) begin
						mode = DRAINING;
					end else begin
						mode = MIXING;
						mixed_left = $urandom_range(10, 30);
					end
				end
			end
		end

		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		while (n_accepted < n_queued || outcome_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken)
				req_busy = 1'b0;
			if (!req_busy && request_q.size() != 0) begin
				if (gap_cnt < request_q[0].gap) begin
					gap_cnt++;
				end else if (!request_q[0].hold || outcome_q.size() == 0) begin
					cur_req  = request_q.pop_front();
					req_busy = 1'b1;
					gap_cnt  = 0;
					req_ch.func       <= cur_req.func;
					req_ch.byte_count <= cur_req.count;
					req_ch.push_bytes <= cur_req.data;
				end
			end
			req_ch.valid <= req_busy;
		end
	end

	// Result sink with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken) begin
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				stall_left = rx_burst ? 0 : $urandom_range(0, 19);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		request_t seen;
		outcome_t want;
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt == CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
			req_taken <= req_ch.valid && req_ch.ready;
			rsp_taken <= rsp_ch.valid && rsp_ch.ready;

			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no transaction outstanding");
					n_errors++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp_ch.done_count !== want.done) begin
						$error("done_count: expected %0d, got %0d", want.done, rsp_ch.done_count);
						n_errors++;
					end
					if (rsp_ch.pop_bytes !== want.bytes) begin
						$error("pop_bytes: expected %h, got %h", want.bytes, rsp_ch.pop_bytes);
						n_errors++;
					end
					if (rsp_ch.fill_level !== want.fill) begin
						$error("fill_level: expected %0d, got %0d", want.fill, rsp_ch.fill_level);
						n_errors++;
					end
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				seen.func  = func_t'(req_ch.func);
				seen.count = req_ch.byte_count;
				seen.data  = req_ch.push_bytes;
				seen.gap   = 0;
				seen.hold  = 1'b0;
				outcome_q.push_back(transfer_outcome(seen));
				n_accepted++;
			end
		end
	end

endmodule

>>> byte_ring_fifo_block_transfer.f
rtl/brf_pkg.sv
rtl/brf_req_if.sv
rtl/brf_rsp_if.sv
rtl/brf_ram.sv
rtl/brf_lane.sv
rtl/byte_ring_fifo_block_transfer.sv
sim/byte_ring_fifo_block_transfer_tb.sv
